/* rtl/md5sd_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 stream digest package
// Shared types, constants and step tables for the MD5 stream digest block.
// ----------------------------------------------------------------------------
package md5sd_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [3:0] chain_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_COMP = 5'b00010,
      ST_PAD  = 5'b00100,
      ST_ZERO = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      RET_IDLE,
      RET_PAD,
      RET_ZERO,
      RET_DONE
   } ret_type;

   typedef struct packed {
      logic       done;
      logic [3:0] msg_idx;
   } core_status_type;

   localparam word_type IV_A = 32'h67452301;
   localparam word_type IV_B = 32'hefcdab89;
   localparam word_type IV_C = 32'h98badcfe;
   localparam word_type IV_D = 32'h10325476;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   localparam word_type STEP_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] i4;
      logic [3:0] k;
      i4 = step[3:0];
      case (step[5:4])
         2'd0:    k = i4;
         2'd1:    k = 4'((i4 << 2) + i4 + 4'd1);
         2'd2:    k = 4'((i4 << 1) + i4 + 4'd5);
         default: k = 4'((i4 << 3) - i4);
      endcase
      return k;
   endfunction

   function automatic word_type bswap32(input word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic word_type put_lane(input word_type w, input logic [1:0] lane,
                                         input logic [7:0] b);
      word_type r;
      r = w;
      case (lane)
         2'd0:    r = {24'd0, b};
         2'd1:    r[15:8] = b;
         2'd2:    r[23:16] = b;
         default: r[31:24] = b;
      endcase
      return r;
   endfunction

endpackage

/* rtl/md5sd_if.sv */
// ----------------------------------------------------------------------------
// MD5 stream digest channels
// Valid/ready channels for message bytes and for digest results.
// ----------------------------------------------------------------------------
interface md5sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       is_last;

   modport source (output valid, output data_byte, output byte_valid,
                   output is_last, input ready);
   modport sink (input valid, input data_byte, input byte_valid,
                 input is_last, output ready);
endinterface

interface md5sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_high;
   logic [63:0] digest_low;

   modport source (output valid, output digest_high, output digest_low,
                   input ready);
   modport sink (input valid, input digest_high, input digest_low,
                 output ready);
endinterface

/* rtl/md5sd_core.sv */
// ----------------------------------------------------------------------------
// MD5 compression step unit
// Runs the 64 MD5 steps of one block on working copies of the chain and hands
// the working words back for the final chain add.
// ----------------------------------------------------------------------------
module md5sd_core
   import md5sd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  chain_type       chain_in,
   input  word_type        msg_word,
   output core_status_type status,
   output chain_type       work
);

   logic [5:0] step_ff, step_in;
   logic       phase_ff, phase_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   word_type   a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   word_type   t_ff, t_in;
   word_type   f;
   logic [4:0] rot;
   logic [63:0] rot_wide;

   always_comb begin
      case (step_ff[5:4])
         2'd0:    f = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1:    f = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2:    f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      rot = ROT_AMOUNT[{step_ff[5:4], step_ff[1:0]}];
      rot_wide = {t_ff, t_ff} << rot;
   end

   always_comb begin
      step_in = step_ff;
      phase_in = phase_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      t_in = t_ff;
      if (start) begin
         a_in = chain_in[0];
         b_in = chain_in[1];
         c_in = chain_in[2];
         d_in = chain_in[3];
         step_in = 6'd0;
         phase_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            t_in = a_ff + f + msg_word + STEP_CONST[step_ff];
            phase_in = 1'b1;
         end else begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + rot_wide[63:32];
            phase_in = 1'b0;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         phase_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         phase_ff <= phase_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      t_ff <= t_in;
   end

   assign status.done = done_ff;
   assign status.msg_idx = msg_index(step_ff);
   assign work = {d_ff, c_ff, b_ff, a_ff};

endmodule

/* rtl/md5sd_top_dummy_removed.sv */
// ----------------------------------------------------------------------------
// MD5 message word store
// Holds the sixteen message words of the current block and applies byte,
// pad, zero-fill and length writes.
// ----------------------------------------------------------------------------
module md5sd_msg
   import md5sd_pkg::*;
(
   input  logic        clock,
   input  logic        byte_we,
   input  logic [5:0]  byte_pos,
   input  logic [7:0]  byte_data,
   input  logic        fill_we,
   input  logic [3:0]  fill_from,
   input  logic        len_we,
   input  logic [63:0] bit_len,
   input  logic [3:0]  rd_idx,
   output word_type    rd_word
);

   word_type msg_ff [16];
   word_type msg_in [16];

   always_comb begin
      for (int w = 0; w < 16; w++) begin
         msg_in[w] = msg_ff[w];
         if (byte_we && byte_pos[5:2] == 4'(w)) begin
            msg_in[w] = put_lane(msg_ff[w], byte_pos[1:0], byte_data);
         end
         if (fill_we && 4'(w) >= fill_from) begin
            msg_in[w] = 32'd0;
         end
      end
      if (len_we) begin
         msg_in[14] = bit_len[31:0];
         msg_in[15] = bit_len[63:32];
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < 16; w++) begin
         msg_ff[w] <= msg_in[w];
      end
   end

   assign rd_word = msg_ff[rd_idx];

endmodule

/* rtl/md5_stream_digest.sv */
// ----------------------------------------------------------------------------
// MD5 stream digest
// Packs message bytes into 64-byte blocks, runs the MD5 compression on each
// full block, pads and finishes the message on its last item and emits the
// 128-bit digest.
// ----------------------------------------------------------------------------
// Items are taken only while idle; one that neither completes a block nor ends
// the message leaves the block idle. An item that completes a 64-byte block
// keeps the block busy while one shared step unit performs the 64 MD5 steps
// and the result is then added into the chain. An item that ends the message
// adds a padding step and one such compression, or, when fewer than nine bytes
// remain free in the block, also a zero-fill step and a second compression,
// and then loads the digest into the output register, which holds it until it
// is taken. That load waits while an earlier digest is still untaken.
module md5_stream_digest
   import md5sd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   md5sd_req_if.sink   req_in,
   md5sd_rsp_if.source rsp_out
);

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;
   chain_type chain_ff, chain_in;
   logic [63:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] dig_high_ff, dig_high_in, dig_low_ff, dig_low_in;

   logic        accept;
   logic        start;
   logic        byte_we;
   logic [5:0]  byte_pos;
   logic [7:0]  byte_data;
   logic        fill_we;
   logic [3:0]  fill_from;
   logic        len_we;
   logic [63:0] count_next;
   word_type    msg_word;
   chain_type   work;
   core_status_type status;

   localparam chain_type IV = {IV_D, IV_C, IV_B, IV_A};

   assign req_in.ready = (state_ff == ST_IDLE);
   assign accept = req_in.valid && req_in.ready;
   assign count_next = count_ff + 64'd1;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_out.ready;
      dig_high_in = dig_high_ff;
      dig_low_in = dig_low_ff;
      start = 1'b0;
      byte_we = 1'b0;
      byte_pos = count_ff[5:0];
      byte_data = req_in.data_byte;
      fill_we = 1'b0;
      fill_from = 4'(count_ff[5:2] + 4'd1);
      len_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_in.byte_valid) begin
                  byte_we = 1'b1;
                  count_in = count_next;
                  if (count_next[5:0] == 6'd0) begin
                     start = 1'b1;
                     ret_in = req_in.is_last ? RET_PAD : RET_IDLE;
                     state_in = ST_COMP;
                  end else if (req_in.is_last) begin
                     state_in = ST_PAD;
                  end
               end else if (req_in.is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            if (status.done) begin
               for (int j = 0; j < 4; j++) begin
                  chain_in[j] = chain_ff[j] + work[j];
               end
               case (ret_ff)
                  RET_IDLE: state_in = ST_IDLE;
                  RET_PAD:  state_in = ST_PAD;
                  RET_ZERO: state_in = ST_ZERO;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_PAD: begin
            byte_we = 1'b1;
            byte_data = PAD_BYTE;
            fill_we = (count_ff[5:2] != 4'd15);
            start = 1'b1;
            state_in = ST_COMP;
            if (count_ff[5:0] < LEN_POS) begin
               len_we = 1'b1;
               ret_in = RET_DONE;
            end else begin
               ret_in = RET_ZERO;
            end
         end
         ST_ZERO: begin
            fill_we = 1'b1;
            fill_from = 4'd0;
            len_we = 1'b1;
            start = 1'b1;
            ret_in = RET_DONE;
            state_in = ST_COMP;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_out.ready) begin
               rsp_valid_in = 1'b1;
               dig_high_in = {bswap32(chain_ff[0]), bswap32(chain_ff[1])};
               dig_low_in = {bswap32(chain_ff[2]), bswap32(chain_ff[3])};
               chain_in = IV;
               count_in = 64'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= RET_IDLE;
         chain_ff <= IV;
         count_ff <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_high_ff <= dig_high_in;
      dig_low_ff <= dig_low_in;
   end

   md5sd_msg u_msg (
      .clock     (clock),
      .byte_we   (byte_we),
      .byte_pos  (byte_pos),
      .byte_data (byte_data),
      .fill_we   (fill_we),
      .fill_from (fill_from),
      .len_we    (len_we),
      .bit_len   ({count_ff[60:0], 3'b000}),
      .rd_idx    (status.msg_idx),
      .rd_word   (msg_word)
   );

   md5sd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .chain_in (chain_ff),
      .msg_word (msg_word),
      .status   (status),
      .work     (work)
   );

   assign rsp_out.valid = rsp_valid_ff;
   assign rsp_out.digest_high = dig_high_ff;
   assign rsp_out.digest_low = dig_low_ff;

endmodule

/* tb/sv/md5_stream_digest_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream digest testbench
// Feeds byte messages of assorted lengths, end markers and idle items through
// the request channel and checks every digest against an in-bench MD5
// predictor, with random gaps in requests and random response backpressure.
// ----------------------------------------------------------------------------
module md5_stream_digest_test;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       is_last;
      logic [1:0] phase;
      logic       hold;
   } byte_item_type;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } digest_type;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 300;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROT_TBL [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   localparam int PHASE_FREE = 0;
   localparam int PHASE_SEND_IDLE = 1;
   localparam int PHASE_RECV_STALL = 2;
   localparam int PHASE_BOTH = 3;

   logic clock;
   logic reset;

   md5sd_req_if req_if();
   md5sd_rsp_if rsp_if();

   md5_stream_digest dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if)
   );

   byte_item_type item_q [$];
   digest_type    digest_q [$];
   byte_item_type cur_item;
   logic [1:0]  cur_phase;
   logic [31:0] chain_q [4];
   logic [31:0] block_words [16];
   logic [63:0] msg_len;
   int          error_count;
   int          cycle_count;

   function automatic int idle_pct(input logic [1:0] phase, input bit sender);
      case (phase)
         PHASE_SEND_IDLE:  return sender ? 69 : 0;
         PHASE_RECV_STALL: return sender ? 0 : 69;
         PHASE_BOTH:       return 24;
         default:          return 0;
      endcase
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic logic [31:0] le_word(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic void load_init_chain();
      chain_q[0] = 32'h67452301;
      chain_q[1] = 32'hefcdab89;
      chain_q[2] = 32'h98badcfe;
      chain_q[3] = 32'h10325476;
      msg_len = 64'd0;
   endfunction

   function automatic void put_byte(input logic [5:0] pos, input logic [7:0] b);
      if (pos[1:0] == 2'd0) begin
         block_words[pos[5:2]] = {24'd0, b};
      end else begin
         block_words[pos[5:2]][pos[1:0] * 8 +: 8] = b;
      end
   endfunction

   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t;
      int r, k;
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      for (int i = 0; i < 64; i++) begin
         r = i / 16;
         case (r)
            0: begin
               f = d ^ (b & (c ^ d));
               k = i % 16;
            end
            1: begin
               f = c ^ (d & (b ^ c));
               k = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               k = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               k = (7 * i) % 16;
            end
         endcase
         t = a + f + block_words[k] + ROUND_K[i];
         t = rol(t, ROT_TBL[r * 4 + i % 4]);
         a = d;
         d = c;
         c = b;
         b = b + t;
      end
      chain_q[0] = chain_q[0] + a;
      chain_q[1] = chain_q[1] + b;
      chain_q[2] = chain_q[2] + c;
      chain_q[3] = chain_q[3] + d;
   endfunction

   function automatic void absorb_item(input byte_item_type it);
      logic [5:0]  pos;
      logic [63:0] bit_len;
      digest_type  dg;
      if (it.byte_valid) begin
         put_byte(msg_len[5:0], it.data_byte);
         msg_len = msg_len + 64'd1;
         if (msg_len[5:0] == 6'd0) begin
            md5_compress();
         end
      end
      if (it.is_last) begin
         pos = msg_len[5:0];
         put_byte(pos, PAD_MARK);
         for (int w = pos / 4 + 1; w < 16; w++) begin
            block_words[w] = 32'd0;
         end
         if (pos >= LEN_OFFSET) begin
            md5_compress();
            for (int w = 0; w < 16; w++) begin
               block_words[w] = 32'd0;
            end
         end
         bit_len = msg_len << 3;
         block_words[14] = bit_len[31:0];
         block_words[15] = bit_len[63:32];
         md5_compress();
         dg.high = {le_word(chain_q[0]), le_word(chain_q[1])};
         dg.low = {le_word(chain_q[2]), le_word(chain_q[3])};
         digest_q.push_back(dg);
         load_init_chain();
      end
   endfunction

   function automatic void push_item(input logic [7:0] data, input bit bv, input bit last,
                                     input int phase, input bit hold);
      byte_item_type it;
      it.data_byte = data;
      it.byte_valid = bv;
      it.is_last = last;
      it.phase = phase[1:0];
      it.hold = hold;
      item_q.push_back(it);
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("md5_stream_digest verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            absorb_item(cur_item);
         end
         if (!req_if.valid || req_if.ready) begin
            if (item_q.size() != 0 && !(item_q[0].hold && digest_q.size() != 0) &&
                $urandom_range(99) >= idle_pct(item_q[0].phase, 1'b1)) begin
               cur_item = item_q.pop_front();
               req_if.valid <= 1'b1;
               req_if.data_byte <= cur_item.data_byte;
               req_if.byte_valid <= cur_item.byte_valid;
               req_if.is_last <= cur_item.is_last;
               cur_phase <= cur_item.phase;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (digest_q.size() == 0) begin
               $error("unexpected digest: digest_high %h digest_low %h",
                      rsp_if.digest_high, rsp_if.digest_low);
               error_count = error_count + 1;
            end else begin
               if (rsp_if.digest_high !== digest_q[0].high) begin
                  $error("digest_high mismatch: expected %h, actual %h",
                         digest_q[0].high, rsp_if.digest_high);
                  error_count = error_count + 1;
               end
               if (rsp_if.digest_low !== digest_q[0].low) begin
                  $error("digest_low mismatch: expected %h, actual %h",
                         digest_q[0].low, rsp_if.digest_low);
                  error_count = error_count + 1;
               end
               void'(digest_q.pop_front());
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b0));
      end
   end

   initial begin : stimulus
      int specials [11];
      int n_items;
      int n_msgs;
      int len;
      int phase;
      int prev_phase;
      bit marker;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = 8'd0;
      req_if.byte_valid = 1'b0;
      req_if.is_last = 1'b0;
      rsp_if.ready = 1'b0;
      cur_phase = PHASE_FREE;
      error_count = 0;
      cycle_count = 0;
      load_init_chain();
      for (int w = 0; w < 16; w++) begin
         block_words[w] = 32'd0;
      end
      specials = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 128};

      push_item(8'h00, 1'b0, 1'b1, PHASE_FREE, 1'b0);
      push_item(8'hff, 1'b0, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h61, 1'b1, 1'b1, PHASE_FREE, 1'b0);
      push_item(8'h00, 1'b1, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h5a, 1'b0, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'hff, 1'b1, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'ha5, 1'b0, 1'b1, PHASE_FREE, 1'b0);
      push_item(8'h61, 1'b1, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h62, 1'b1, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h63, 1'b1, 1'b1, PHASE_FREE, 1'b0);
      push_item(8'hff, 1'b0, 1'b1, PHASE_FREE, 1'b0);
      push_item(8'h80, 1'b1, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h7f, 1'b1, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h00, 1'b0, 1'b0, PHASE_FREE, 1'b0);
      push_item(8'h01, 1'b1, 1'b1, PHASE_FREE, 1'b0);

      n_items = 0;
      n_msgs = 0;
      prev_phase = -1;
      while (n_items < 2000 || n_msgs < 40) begin
         phase = (n_items / 500 > 3) ? PHASE_BOTH : n_items / 500;
         if ($urandom_range(1) == 0) begin
            len = specials[$urandom_range(10)];
         end else begin
            len = $urandom_range(150);
         end
         marker = (len == 0) || ($urandom_range(2) == 0);
         for (int b = 0; b < len; b++) begin
            if ($urandom_range(99) < 8) begin
               push_item(8'($urandom), 1'b0, 1'b0, phase, 1'b0);
            end
            push_item(8'($urandom), 1'b1, !marker && b == len - 1, phase,
                      b == 0 && phase != prev_phase);
            n_items++;
         end
         if (marker) begin
            push_item(8'($urandom), 1'b0, 1'b1, phase, len == 0 && phase != prev_phase);
            n_items++;
         end
         prev_phase = phase;
         n_msgs++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (item_q.size() != 0 || req_if.valid) @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("md5_stream_digest verification clean");
      end else begin
         $display("md5_stream_digest verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/md5sd_pkg.sv
rtl/md5sd_if.sv
rtl/md5sd_core.sv
rtl/md5sd_top_dummy_removed.sv
rtl/md5_stream_digest.sv
tb/sv/md5_stream_digest_test.sv
